### rtl/etw_pkg.sv
`timescale 1ns / 1ps
package etw_pkg;

  // fixed-point layout
  localparam int SCALE_FRAC_BITS = 16;
  localparam int Q_FRAC_BITS     = 8;
  localparam int SH_MAX          = SCALE_FRAC_BITS + Q_FRAC_BITS;

  localparam int DATA_W  = 16;
  localparam int SCALE_W = 24;
  localparam int OPND_W  = DATA_W + 1;             // operand after format extension
  localparam int SUM_W   = OPND_W + 1;             // add/sub result
  localparam int ABS_W   = DATA_W;                 // |operand| <= 2^15
  localparam int MAG_W   = 2 * ABS_W - 1;          // |a*b| <= 2^30
  localparam int M_W     = MAG_W + SCALE_W;        // scaled product magnitude
  localparam int Q_W     = M_W - SCALE_FRAC_BITS;  // quotient after the smaller shift
  localparam int R_W     = Q_W + 1;                // signed result before range step

  // register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_OPERATION     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_FORMAT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_NEAREST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR  = 3'd4;

  // operation codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;

  // number format codes
  localparam logic [1:0] FMT_Q78 = 2'd0;
  localparam logic [1:0] FMT_U8  = 2'd1;
  localparam logic [1:0] FMT_S8  = 2'd2;

  // format ranges
  localparam int Q78_MIN = -32768;
  localparam int Q78_MAX = 32767;
  localparam int U8_MIN  = 0;
  localparam int U8_MAX  = 255;
  localparam int S8_MIN  = -128;
  localparam int S8_MAX  = 127;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

  typedef struct packed {
    logic [1:0]         operation;
    logic [1:0]         number_format;
    logic               wrap_mode;
    logic               round_nearest;
    logic [SCALE_W-1:0] scale_factor;
  } cfg_t;

  // beat leaving the operand stage
  typedef struct packed {
    logic                    zero;
    logic                    is_mul;
    logic                    neg;
    logic signed [SUM_W-1:0] sum;
    logic [MAG_W-1:0]        mag;
  } front_beat_t;

  // beat leaving the rounding stage
  typedef struct packed {
    logic                    zero;
    logic                    is_mul;
    logic                    neg;
    logic signed [SUM_W-1:0] sum;
    logic [Q_W-1:0]          q;
  } round_beat_t;

endpackage

### rtl/elementwise_tensor_arith_unit.sv
`timescale 1ns / 1ps
// Elementwise add, subtract or scaled multiply of two tensor elements in Q7.8, U8 or S8,
// with wrap or saturate on overflow and nearest-even or truncating rounding of the
// scaled product. The unit is a four-stage pipeline (operand decode and 16x16 product,
// 31x24 scale multiply, rounding, range handling into the output register): it takes a
// new beat every clock cycle while the output side does not stall; a stall holds each
// beat in its stage until the next stage has room. The scale multiply is the deepest
// stage. Registers are written through cfg_write/cfg_index/cfg_data and must only change
// while the pipeline is empty; unused operation or format codes give a result of zero.
module elementwise_tensor_arith_unit import etw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [SCALE_W-1:0]       cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] first_operand,
  input  logic signed [DATA_W-1:0] second_operand,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] result_value
);

  cfg_t        cfg;
  logic        front_valid, front_ready;
  front_beat_t front_beat;
  logic        round_valid, round_ready;
  round_beat_t round_beat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.operation     <= OP_ADD;
      cfg.number_format <= FMT_Q78;
      cfg.wrap_mode     <= 1'b0;
      cfg.round_nearest <= 1'b1;
      cfg.scale_factor  <= SCALE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_OPERATION:     cfg.operation     <= cfg_data[1:0];
        REG_NUMBER_FORMAT: cfg.number_format <= cfg_data[1:0];
        REG_WRAP_MODE:     cfg.wrap_mode     <= cfg_data[0];
        REG_ROUND_NEAREST: cfg.round_nearest <= cfg_data[0];
        REG_SCALE_FACTOR:  cfg.scale_factor  <= cfg_data;
        default: ;
      endcase
    end
  end

  etw_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .first_operand  (first_operand),
    .second_operand (second_operand),
    .out_valid      (front_valid),
    .out_ready      (front_ready),
    .out_beat       (front_beat)
  );

  etw_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_beat   (front_beat),
    .out_valid (round_valid),
    .out_ready (round_ready),
    .out_beat  (round_beat)
  );

  etw_clamp u_clamp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (round_valid),
    .in_ready     (round_ready),
    .in_beat      (round_beat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value)
  );

  // back-pressure reaches the input only when every stage holds a beat
  a_full_before_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (front_valid && round_valid && out_valid && !out_ready))
    else $error("input stalled with room in the pipeline");

  // a beat in the operand stage is never dropped while the next stage is full
  a_front_holds: assert property (@(posedge clk) disable iff (rst)
    (front_valid && !front_ready) |=> front_valid)
    else $error("operand stage lost a beat");

  // a beat leaving the rounding stage always lands in the output register
  a_round_to_out: assert property (@(posedge clk) disable iff (rst)
    (round_valid && round_ready) |=> out_valid)
    else $error("rounded beat did not reach the output");

endmodule

### rtl/etw_front.sv
`timescale 1ns / 1ps
module etw_front import etw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] first_operand,
  input  logic signed [DATA_W-1:0] second_operand,
  output logic                     out_valid,
  input  logic                     out_ready,
  output front_beat_t              out_beat
);

  logic signed [OPND_W-1:0] a, b, a_neg, b_neg;
  logic [ABS_W-1:0]         a_abs, b_abs;
  front_beat_t              beat_next;
  logic                     vld;
  front_beat_t              beat;

  // operand extension per format
  always_comb begin
    case (cfg.number_format)
      FMT_Q78: begin
        a = OPND_W'(first_operand);
        b = OPND_W'(second_operand);
      end
      FMT_U8: begin
        a = signed'({9'd0, first_operand[7:0]});
        b = signed'({9'd0, second_operand[7:0]});
      end
      default: begin
        a = signed'({{9{first_operand[7]}}, first_operand[7:0]});
        b = signed'({{9{second_operand[7]}}, second_operand[7:0]});
      end
    endcase
  end

  // sum or difference, and product magnitude from the operand magnitudes
  always_comb begin
    a_neg = -a;
    b_neg = -b;
    a_abs = a[OPND_W-1] ? ABS_W'(a_neg) : ABS_W'(a);
    b_abs = b[OPND_W-1] ? ABS_W'(b_neg) : ABS_W'(b);
    beat_next.zero   = !(cfg.number_format inside {FMT_Q78, FMT_U8, FMT_S8}) ||
                       !(cfg.operation inside {OP_ADD, OP_SUB, OP_MUL});
    beat_next.is_mul = (cfg.operation == OP_MUL);
    beat_next.neg    = a[OPND_W-1] ^ b[OPND_W-1];
    beat_next.sum    = (cfg.operation == OP_SUB) ? SUM_W'(a) - SUM_W'(b)
                                                 : SUM_W'(a) + SUM_W'(b);
    // magnitude never exceeds 2^30, top product bit is always zero
    beat_next.mag    = MAG_W'(a_abs * b_abs);
  end

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat <= beat_next;
    end
  end

  assign out_valid = vld;
  assign out_beat  = beat;

endmodule

### rtl/etw_scale.sv
`timescale 1ns / 1ps
module etw_scale import etw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  front_beat_t in_beat,
  output logic        out_valid,
  input  logic        out_ready,
  output round_beat_t out_beat
);

  // scale multiply stage
  logic                    mul_vld;
  logic                    mul_ready;
  logic [M_W-1:0]          m;
  logic                    mul_zero, mul_is_mul, mul_neg;
  logic signed [SUM_W-1:0] mul_sum;

  // rounding stage
  logic                    rnd_vld;
  logic                    rnd_ready;
  round_beat_t             rnd_beat;
  round_beat_t             rnd_beat_next;
  logic [Q_W-1:0]          q_raw;
  logic [SH_MAX-1:0]       rem, half;
  logic                    round_up;

  assign mul_ready = !mul_vld || rnd_ready;
  assign rnd_ready = !rnd_vld || out_ready;
  assign in_ready  = mul_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
      rnd_vld <= 1'b0;
    end else begin
      if (mul_ready) begin
        mul_vld <= in_valid;
      end
      if (rnd_ready) begin
        rnd_vld <= mul_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && mul_ready) begin
      m          <= M_W'(in_beat.mag) * M_W'(cfg.scale_factor);
      mul_zero   <= in_beat.zero;
      mul_is_mul <= in_beat.is_mul;
      mul_neg    <= in_beat.neg;
      mul_sum    <= in_beat.sum;
    end
  end

  // drop fraction bits, round half to even on the magnitude when round_nearest is set, else truncate
  always_comb begin
    if (cfg.number_format == FMT_Q78) begin
      q_raw = Q_W'(m >> SH_MAX);
      rem   = m[SH_MAX-1:0];
      half  = SH_MAX'(1) << (SH_MAX - 1);
    end else begin
      q_raw = Q_W'(m >> SCALE_FRAC_BITS);
      rem   = SH_MAX'(m[SCALE_FRAC_BITS-1:0]);
      half  = SH_MAX'(1) << (SCALE_FRAC_BITS - 1);
    end
    round_up = cfg.round_nearest && ((rem > half) || ((rem == half) && q_raw[0]));
    rnd_beat_next.zero   = mul_zero;
    rnd_beat_next.is_mul = mul_is_mul;
    rnd_beat_next.neg    = mul_neg;
    rnd_beat_next.sum    = mul_sum;
    rnd_beat_next.q      = q_raw + Q_W'(round_up);
  end

  always_ff @(posedge clk) begin
    if (mul_vld && rnd_ready) begin
      rnd_beat <= rnd_beat_next;
    end
  end

  assign out_valid = rnd_vld;
  assign out_beat  = rnd_beat;

endmodule

### rtl/etw_clamp.sv
`timescale 1ns / 1ps
module etw_clamp import etw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  round_beat_t              in_beat,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] result_value
);

  logic signed [R_W-1:0]    q_s, r, lo, hi;
  logic signed [DATA_W-1:0] wrapped, clamped;
  logic signed [DATA_W-1:0] result_next;
  logic                     vld;
  logic signed [DATA_W-1:0] result;

  // signed result and format range
  always_comb begin
    q_s = signed'(R_W'(in_beat.q));
    if (in_beat.is_mul) begin
      r = in_beat.neg ? -q_s : q_s;
    end else begin
      r = R_W'(in_beat.sum);
    end
    case (cfg.number_format)
      FMT_Q78: begin
        lo      = R_W'(Q78_MIN);
        hi      = R_W'(Q78_MAX);
        wrapped = r[DATA_W-1:0];
      end
      FMT_U8: begin
        lo      = R_W'(U8_MIN);
        hi      = R_W'(U8_MAX);
        wrapped = signed'({8'd0, r[7:0]});
      end
      default: begin
        lo      = R_W'(S8_MIN);
        hi      = R_W'(S8_MAX);
        wrapped = signed'({{8{r[7]}}, r[7:0]});
      end
    endcase
  end

  // wrap or saturate, invalid codes give zero
  always_comb begin
    if (r < lo) begin
      clamped = DATA_W'(lo);
    end else if (r > hi) begin
      clamped = DATA_W'(hi);
    end else begin
      clamped = DATA_W'(r);
    end
    if (in_beat.zero) begin
      result_next = '0;
    end else if (cfg.wrap_mode) begin
      result_next = wrapped;
    end else begin
      result_next = clamped;
    end
  end

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      result <= result_next;
    end
  end

  assign out_valid    = vld;
  assign result_value = result;

endmodule
